// ===== src/rdrw_pkg.sv =====
// ----------------------------------------------------------------------------
// rdrw_pkg: shared types and constants of the rolling day reject window
// widths of the stream fields, reciprocal constants for the minute-of-day
// math and the item passed from the time path to the bin window
// ----------------------------------------------------------------------------
package rdrw_pkg;

  localparam int unsigned WINDOW_MINUTES_DEF = 1440;

  localparam int unsigned EPOCH_W = 32;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned BIN_W   = 16;
  localparam int unsigned MIN_W   = 11;
  localparam int unsigned TOTAL_W = 27;
  localparam int unsigned OFF_W   = 5;
  localparam int unsigned OFFS_W  = 17;  // offset in seconds, signed
  localparam int unsigned DAY_W   = 17;  // seconds of the day

  localparam logic [MIN_W-1:0] NO_MINUTE = 11'd2047;
  localparam logic [BIN_W-1:0] BIN_MAX   = 16'hFFFF;

  localparam int unsigned DAY_SECONDS  = 86400;
  localparam int unsigned HOUR_SECONDS = 3600;

  // 86400 = 675 << 7
  localparam int unsigned DAY_LO_W  = 7;
  localparam int unsigned DAY_ODD   = 675;
  localparam int unsigned DAY_HI_W  = EPOCH_W - DAY_LO_W;  // 25
  localparam int unsigned ODD_REM_W = 10;
  localparam int unsigned DAYS_W    = 16;                  // epoch / 86400 < 2^16

  // ceil(2^35 / 675), exact floor division for 25-bit dividends
  localparam int unsigned          RECIP_675_SH = 35;
  localparam logic [25:0]          RECIP_675    = 26'd50903317;
  // ceil(2^23 / 60), exact floor division for dividends below 86400
  localparam int unsigned          RECIP_60_SH  = 23;
  localparam logic [17:0]          RECIP_60     = 18'd139811;

  // configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_UTC_OFFSET = 1'b0;  // register index bit, paddr[2]

  typedef struct packed {
    logic [MIN_W-1:0] minute;
    logic [BIN_W-1:0] bin_val;
  } minute_item_t;

endpackage

// ===== src/rdrw_minute_calc.sv =====
// ----------------------------------------------------------------------------
// rdrw_minute_calc: local minute of the day
// five-stage pipeline: saturated reject sum, epoch mod 86400 by reciprocal,
// utc offset with day wrap, division by 60 by reciprocal
// ----------------------------------------------------------------------------
module rdrw_minute_calc (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [rdrw_pkg::EPOCH_W-1:0]            epoch_i,
  input  logic [rdrw_pkg::COUNT_W-1:0]            guard_i,
  input  logic [rdrw_pkg::COUNT_W-1:0]            thresh_i,
  input  logic signed [rdrw_pkg::OFFS_W-1:0]      off_secs_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output rdrw_pkg::minute_item_t                  out_item_o
);

  localparam int unsigned STAGES = 5;
  localparam int unsigned SUM_W  = rdrw_pkg::COUNT_W + 1;
  localparam int unsigned BPROD_W = rdrw_pkg::DAY_HI_W + 26;
  localparam int unsigned CREM_W  = 26;
  localparam int unsigned DSUM_W  = rdrw_pkg::DAY_W + 2;
  localparam int unsigned EPROD_W = rdrw_pkg::DAY_W + 18;

  logic [STAGES-1:0] valid_q;
  logic [STAGES:0]   en;

  // stage a: input
  logic [rdrw_pkg::EPOCH_W-1:0] a_epoch_q;
  logic [rdrw_pkg::BIN_W-1:0]   a_bin_q;
  logic [SUM_W-1:0]             in_sum;
  logic [rdrw_pkg::BIN_W-1:0]   in_bin;
  // stage b: days quotient
  logic [rdrw_pkg::DAY_HI_W-1:0] b_x_q;
  logic [rdrw_pkg::DAY_LO_W-1:0] b_lo_q;
  logic [rdrw_pkg::DAYS_W-1:0]   b_q_q;
  logic [rdrw_pkg::BIN_W-1:0]    b_bin_q;
  logic [BPROD_W-1:0]            b_prod;
  // stage c: seconds of the utc day
  logic [rdrw_pkg::DAY_W-1:0]    c_secs_q;
  logic [rdrw_pkg::BIN_W-1:0]    c_bin_q;
  logic [CREM_W-1:0]             c_rem;
  // stage d: seconds of the local day
  logic [rdrw_pkg::DAY_W-1:0]    d_secs_q;
  logic [rdrw_pkg::BIN_W-1:0]    d_bin_q;
  logic signed [DSUM_W-1:0]      d_sum;
  logic [rdrw_pkg::DAY_W-1:0]    d_secs;
  // stage e: minute
  logic [rdrw_pkg::MIN_W-1:0]    e_min_q;
  logic [rdrw_pkg::BIN_W-1:0]    e_bin_q;
  logic [EPROD_W-1:0]            e_prod;

  // a stage moves on when it is empty or the next one moves
  always_comb begin
    en[STAGES] = out_ready_i;
    for (int i = STAGES - 1; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  // wide sum, then saturate
  always_comb begin
    in_sum = SUM_W'(guard_i) + SUM_W'(thresh_i);
    in_bin = (|in_sum[SUM_W-1:rdrw_pkg::BIN_W]) ? rdrw_pkg::BIN_MAX
                                                : in_sum[rdrw_pkg::BIN_W-1:0];
  end

  assign b_prod = BPROD_W'(a_epoch_q[rdrw_pkg::EPOCH_W-1:rdrw_pkg::DAY_LO_W])
                * BPROD_W'(rdrw_pkg::RECIP_675);

  assign c_rem = CREM_W'(b_x_q) - CREM_W'(b_q_q) * CREM_W'(rdrw_pkg::DAY_ODD);

  // offset can push the time a day either way
  always_comb begin
    d_sum = $signed({2'b00, c_secs_q}) + DSUM_W'(off_secs_i);
    if (d_sum < 0) begin
      d_secs = rdrw_pkg::DAY_W'(d_sum + DSUM_W'(rdrw_pkg::DAY_SECONDS));
    end else if (d_sum >= $signed(DSUM_W'(rdrw_pkg::DAY_SECONDS))) begin
      d_secs = rdrw_pkg::DAY_W'(d_sum - DSUM_W'(rdrw_pkg::DAY_SECONDS));
    end else begin
      d_secs = rdrw_pkg::DAY_W'(d_sum);
    end
  end

  assign e_prod = EPROD_W'(d_secs_q) * EPROD_W'(rdrw_pkg::RECIP_60);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_epoch_q <= epoch_i;
      a_bin_q   <= in_bin;
    end
    if (en[1]) begin
      b_x_q   <= a_epoch_q[rdrw_pkg::EPOCH_W-1:rdrw_pkg::DAY_LO_W];
      b_lo_q  <= a_epoch_q[rdrw_pkg::DAY_LO_W-1:0];
      b_q_q   <= b_prod[rdrw_pkg::RECIP_675_SH +: rdrw_pkg::DAYS_W];
      b_bin_q <= a_bin_q;
    end
    if (en[2]) begin
      c_secs_q <= {c_rem[rdrw_pkg::ODD_REM_W-1:0], b_lo_q};
      c_bin_q  <= b_bin_q;
    end
    if (en[3]) begin
      d_secs_q <= d_secs;
      d_bin_q  <= c_bin_q;
    end
    if (en[4]) begin
      e_min_q <= e_prod[rdrw_pkg::RECIP_60_SH +: rdrw_pkg::MIN_W];
      e_bin_q <= d_bin_q;
    end
  end

  assign out_item_o.minute  = e_min_q;
  assign out_item_o.bin_val = e_bin_q;

endmodule

// ===== src/rdrw_bin_window.sv =====
// ----------------------------------------------------------------------------
// rdrw_bin_window: ring of per-minute bins and the running total
// roll decision and bin read in one stage, subtract, add and write back in
// the next; a first-pass flag stands in for the cleared bins after reset
// ----------------------------------------------------------------------------
module rdrw_bin_window #(
  parameter int unsigned WINDOW_MINUTES = rdrw_pkg::WINDOW_MINUTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rdrw_pkg::minute_item_t            in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              rolled_o,
  output logic [rdrw_pkg::BIN_W-1:0]        bin_val_o,
  output logic [rdrw_pkg::TOTAL_W-1:0]      total_o
);

  localparam int unsigned IDX_W = $clog2(WINDOW_MINUTES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_MINUTES - 1);

  logic [rdrw_pkg::BIN_W-1:0] bins_mem [WINDOW_MINUTES];

  logic [rdrw_pkg::MIN_W-1:0]   last_min_q, last_min_d;
  logic [IDX_W-1:0]             idx_q, idx_d;
  logic                         wrapped_q, wrapped_d;
  logic [rdrw_pkg::TOTAL_W-1:0] total_q, total_d;

  logic                         m_valid_q;
  logic                         m_roll_q;
  logic                         m_first_q;
  logic [IDX_W-1:0]             m_idx_q;
  logic [rdrw_pkg::BIN_W-1:0]   m_val_q;
  logic [rdrw_pkg::BIN_W-1:0]   rd_data_q;

  logic                         out_valid_q;
  logic                         out_rolled_q;
  logic [rdrw_pkg::BIN_W-1:0]   out_val_q;
  logic [rdrw_pkg::TOTAL_W-1:0] out_total_q;

  logic                         en_out, en_m, take, roll, wr_en;
  logic [rdrw_pkg::BIN_W-1:0]   old_val;

  assign en_out     = !out_valid_q || out_ready_i;
  assign en_m       = !m_valid_q || en_out;
  assign in_ready_o = en_m;
  assign take       = en_m && in_valid_i;
  assign roll       = in_item_i.minute != last_min_q;
  assign wr_en      = en_out && m_valid_q && m_roll_q;

  // bins not yet written since reset read as zero
  assign old_val = m_first_q ? '0 : rd_data_q;

  always_comb begin
    last_min_d = last_min_q;
    idx_d      = idx_q;
    wrapped_d  = wrapped_q;
    if (take && roll) begin
      last_min_d = in_item_i.minute;
      if (idx_q == IDX_LAST) begin
        idx_d     = '0;
        wrapped_d = 1'b1;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_comb begin
    total_d = total_q;
    if (wr_en) begin
      total_d = total_q - rdrw_pkg::TOTAL_W'(old_val) + rdrw_pkg::TOTAL_W'(m_val_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_min_q  <= rdrw_pkg::NO_MINUTE;
      idx_q       <= '0;
      wrapped_q   <= 1'b0;
      total_q     <= '0;
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      last_min_q <= last_min_d;
      idx_q      <= idx_d;
      wrapped_q  <= wrapped_d;
      total_q    <= total_d;
      if (en_m) begin
        m_valid_q <= in_valid_i;
      end
      if (en_out) begin
        out_valid_q <= m_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_m) begin
      m_roll_q  <= roll;
      m_first_q <= !wrapped_q;
      m_idx_q   <= idx_q;
      m_val_q   <= in_item_i.bin_val;
      rd_data_q <= bins_mem[idx_q];
    end
    if (en_out) begin
      out_rolled_q <= m_roll_q;
      out_val_q    <= m_roll_q ? m_val_q : '0;
      out_total_q  <= total_d;
    end
  end

  // successive rolls touch successive bins, so a read never meets a pending write
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bins_mem[m_idx_q] <= m_val_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rolled_o    = out_rolled_q;
  assign bin_val_o   = out_val_q;
  assign total_o     = out_total_q;

endmodule

// ===== src/rolling_day_reject_window_unit.sv =====
// ----------------------------------------------------------------------------
// rolling_day_reject_window_unit: 24-hour reject window in minute bins
// takes a time stamp and two reject counts per request, rolls a ring of
// per-minute bins on each new local minute and reports the window total
//
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tdata: epoch, guard, threshold counts
// m_axis    out  tvalid/tready          tdata: bin value, total; tuser: rolled
// apb       in   psel/penable/pready    utc_offset_hours at address 0
//
// one request per cycle sustained while the output is not stalled
// the bin memory read-modify-write spans two stages, one bin per roll
// reset clears the pipeline; no clearing pass, bins read as zero until the
// ring has been filled once
// a stalled output fills the pipeline, then s_axis_tready drops
// ----------------------------------------------------------------------------
module rolling_day_reject_window_unit #(
  parameter int unsigned WINDOW_MINUTES = rdrw_pkg::WINDOW_MINUTES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [31:0] epoch_seconds, [63:32] guard_rejects, [95:64] threshold_rejects
  input  logic [95:0]                        s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [15:0] minute_bin_value, [42:16] window_total, [47:43] zero
  output logic [47:0]                        m_axis_tdata,
  // [0] rolled
  output logic [0:0]                         m_axis_tuser,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rdrw_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [rdrw_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rdrw_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam longint unsigned TOTAL_MAX = longint'(WINDOW_MINUTES) * 65535;

  logic signed [rdrw_pkg::OFF_W-1:0]  off_q;
  logic signed [rdrw_pkg::OFFS_W-1:0] off_secs_q;
  logic                               cfg_wr;

  logic                               mc_valid, mc_ready;
  rdrw_pkg::minute_item_t             mc_item;
  logic                               rolled;
  logic [rdrw_pkg::BIN_W-1:0]         bin_val;
  logic [rdrw_pkg::TOTAL_W-1:0]       total;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == rdrw_pkg::REG_UTC_OFFSET);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q      <= '0;
      off_secs_q <= '0;
    end else if (cfg_wr) begin
      off_q      <= $signed(pwdata[rdrw_pkg::OFF_W-1:0]);
      off_secs_q <= rdrw_pkg::OFFS_W'($signed(pwdata[rdrw_pkg::OFF_W-1:0]))
                  * $signed(rdrw_pkg::OFFS_W'(rdrw_pkg::HOUR_SECONDS));
    end
  end

  assign prdata = (paddr[2] == rdrw_pkg::REG_UTC_OFFSET)
                ? rdrw_pkg::APB_DATA_W'(off_q) : '0;

  rdrw_minute_calc u_minute_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .epoch_i     (s_axis_tdata[31:0]),
    .guard_i     (s_axis_tdata[63:32]),
    .thresh_i    (s_axis_tdata[95:64]),
    .off_secs_i  (off_secs_q),
    .out_valid_o (mc_valid),
    .out_ready_i (mc_ready),
    .out_item_o  (mc_item)
  );

  rdrw_bin_window #(
    .WINDOW_MINUTES (WINDOW_MINUTES)
  ) u_bin_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mc_valid),
    .in_ready_o  (mc_ready),
    .in_item_i   (mc_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .rolled_o    (rolled),
    .bin_val_o   (bin_val),
    .total_o     (total)
  );

  assign m_axis_tdata = {5'b0, total, bin_val};
  assign m_axis_tuser = rolled;

  // a request without a roll stores nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[15:0] == '0)
    else $error("bin value reported without a roll");

  // the total is a sum of the bins in the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[42:16] <= rdrw_pkg::TOTAL_W'(TOTAL_MAX))
    else $error("window total beyond the full ring");

  // input back-pressure only comes from a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while the output is free");

  // the offset register follows its write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> off_q == $past(pwdata[rdrw_pkg::OFF_W-1:0]))
    else $error("offset register missed a write");

endmodule

// ===== tb/sv/rolling_day_reject_window_unit_tb.sv =====
// ----------------------------------------------------------------------------
// rolling_day_reject_window_unit_tb: self-checking bench of the reject window
// streams time stamps and reject counts through the unit under random
// sender bursts and receiver stalls, predicts every result with a local
// model of the minute ring and checks each returned result in order;
// the utc offset register is swept between phases
// ----------------------------------------------------------------------------
module rolling_day_reject_window_unit_tb;
  import rdrw_pkg::*;

  localparam int unsigned RING_DEPTH     = WINDOW_MINUTES_DEF;
  localparam int          MINUTE_SECONDS = 60;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned STALL_LIMIT    = 4000;
  localparam int unsigned PHASE_ITEMS    = 276;
  localparam logic [APB_ADDR_W-1:0] UTC_OFFSET_ADDR = {REG_UTC_OFFSET, 2'b00};

  // epoch in the lowest bits, as on s_axis_tdata
  typedef struct packed {
    logic [COUNT_W-1:0] thresh;
    logic [COUNT_W-1:0] guard;
    logic [EPOCH_W-1:0] epoch;
  } reject_request_t;

  typedef struct packed {
    logic               rolled;
    logic [BIN_W-1:0]   bin_val;
    logic [TOTAL_W-1:0] total;
  } window_result_t;

  logic                  clk_i;
  logic                  rst_ni         = 1'b0;
  logic                  s_axis_tvalid  = 1'b0;
  logic                  s_axis_tready;
  logic [95:0]           s_axis_tdata   = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready  = 1'b0;
  logic [47:0]           m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [APB_ADDR_W-1:0] paddr          = '0;
  logic [APB_DATA_W-1:0] pwdata         = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rolling_day_reject_window_unit #(
    .WINDOW_MINUTES(RING_DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // local copy of the window state
  logic signed [OFF_W-1:0] offset_hours;
  logic [MIN_W-1:0]        prev_minute;
  logic [BIN_W-1:0]        minute_ring [RING_DEPTH];
  logic [MIN_W-1:0]        ring_pos;
  logic [TOTAL_W-1:0]      window_sum;

  reject_request_t pending_requests[$];
  window_result_t  expected_results[$];
  reject_request_t next_req;

  int unsigned fail_count    = 0;
  int unsigned requests_sent = 0;
  int unsigned rolls_seen    = 0;
  int unsigned results_seen  = 0;
  int unsigned offsets_set   = 0;
  int unsigned burst_left    = 0;
  int unsigned gap_left      = 0;
  int unsigned stall_mode    = 0;
  int unsigned stall_left    = 0;
  int unsigned idle_cycles   = 0;

  function automatic window_result_t predict_window(reject_request_t req);
    longint           local_secs;
    longint           day_secs;
    logic [MIN_W-1:0] minute;
    logic [COUNT_W:0] wide_sum;
    logic [BIN_W-1:0] bin_val;
    window_result_t   res;
    local_secs = longint'(req.epoch) + longint'(offset_hours) * longint'(HOUR_SECONDS);
    day_secs   = local_secs % longint'(DAY_SECONDS);
    // floor remainder for a negative local time
    if (day_secs < 0) begin
      day_secs = day_secs + longint'(DAY_SECONDS);
    end
    minute = MIN_W'(day_secs / MINUTE_SECONDS);
    if (minute == prev_minute) begin
      res.rolled  = 1'b0;
      res.bin_val = '0;
      res.total   = window_sum;
    end else begin
      prev_minute = minute;
      if (ring_pos >= RING_DEPTH) begin
        ring_pos = '0;
      end
      wide_sum   = {1'b0, req.guard} + {1'b0, req.thresh};
      bin_val    = (wide_sum > BIN_MAX) ? BIN_MAX : wide_sum[BIN_W-1:0];
      window_sum = window_sum - TOTAL_W'(minute_ring[ring_pos]) + TOTAL_W'(bin_val);
      minute_ring[ring_pos] = bin_val;
      ring_pos    = (ring_pos == RING_DEPTH - 1) ? '0 : ring_pos + 1'b1;
      res.rolled  = 1'b1;
      res.bin_val = bin_val;
      res.total   = window_sum;
      rolls_seen++;
    end
    return res;
  endfunction

  // request driver: bursts of random length separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(predict_window(s_axis_tdata));
        requests_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          next_req = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_req;
          if (burst_left <= 1) begin
            // now and then a long burst with no gap at all
            if ($urandom_range(0, 7) == 0) begin
              burst_left <= 64;
              gap_left   <= 0;
            end else begin
              burst_left <= $urandom_range(1, 20);
              gap_left   <= $urandom_range(0, 10);
            end
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_mode    <= 0;
      stall_left    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result rolled=%0b bin=%0d total=%0d", $time,
                   m_axis_tuser[0], m_axis_tdata[15:0], m_axis_tdata[42:16]);
          fail_count++;
        end else begin
          window_result_t exp_res;
          exp_res = expected_results.pop_front();
          if (m_axis_tuser[0] !== exp_res.rolled) begin
            $display("%0t: rolled mismatch expected %0b actual %0b", $time,
                     exp_res.rolled, m_axis_tuser[0]);
            fail_count++;
          end
          if (m_axis_tdata[15:0] !== exp_res.bin_val) begin
            $display("%0t: minute bin mismatch expected %0d actual %0d", $time,
                     exp_res.bin_val, m_axis_tdata[15:0]);
            fail_count++;
          end
          if (m_axis_tdata[42:16] !== exp_res.total) begin
            $display("%0t: window total mismatch expected %0d actual %0d", $time,
                     exp_res.total, m_axis_tdata[42:16]);
            fail_count++;
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(20, 200);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: begin
          m_axis_tready <= 1'b1;
        end
        1: begin
          m_axis_tready <= ($urandom_range(0, 9) < 7);
        end
        2: begin
          m_axis_tready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          // full stall long enough to back the pipeline up
          m_axis_tready <= (stall_left > 60);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
                 idle_cycles, expected_results.size());
        $display("rolling_day_reject_window_unit_tb: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_request(input logic [EPOCH_W-1:0] epoch,
                              input logic [COUNT_W-1:0] guard,
                              input logic [COUNT_W-1:0] thresh);
    reject_request_t req;
    req.epoch  = epoch;
    req.guard  = guard;
    req.thresh = thresh;
    pending_requests.push_back(req);
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk_i);
    end while (pending_requests.size() != 0 || s_axis_tvalid ||
               expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // write the offset, then read it back
  task automatic set_offset(input logic signed [OFF_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= UTC_OFFSET_ADDR;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    offset_hours = value;
    offsets_set++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[OFF_W-1:0] !== value) begin
      $display("%0t: offset readback mismatch expected %0d actual %0d", $time,
               value, $signed(prdata[OFF_W-1:0]));
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned count);
    logic [EPOCH_W-1:0] epoch;
    logic [COUNT_W-1:0] guard;
    logic [COUNT_W-1:0] thresh;
    int unsigned        pick;
    epoch = $urandom();
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // same epoch again: no roll
      end else if (pick < 20) begin
        epoch = $urandom();
      end else begin
        // 60..119 s later is always a different minute
        epoch = epoch + 60 + $urandom_range(0, 59);
      end
      case ($urandom_range(0, 3))
        0: begin
          guard  = $urandom_range(0, 2000);
          thresh = $urandom_range(0, 2000);
        end
        1: begin
          // around the saturation point
          guard  = $urandom_range(0, 65535);
          thresh = 65535 - guard + $urandom_range(0, 2) - 1;
        end
        2: begin
          guard  = $urandom();
          thresh = $urandom();
        end
        default: begin
          guard  = ($urandom_range(0, 1) == 0) ? '0 : $urandom();
          thresh = ($urandom_range(0, 1) == 0) ? '0 : $urandom_range(0, 65535);
        end
      endcase
      push_request(epoch, guard, thresh);
    end
  endtask

  initial begin
    offset_hours = '0;
    prev_minute  = NO_MINUTE;
    ring_pos     = '0;
    window_sum   = '0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      minute_ring[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset offset: extremes of the counts and of the epoch
    push_request(32'd0, 32'd0, 32'd0);
    push_request(32'd59, 32'd5, 32'd7);
    push_request(32'd60, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(32'd120, 32'd65535, 32'd0);
    push_request(32'd180, 32'd65535, 32'd1);
    push_request(32'd240, 32'h8000_0000, 32'h8000_0000);
    push_request(32'hFFFF_FFFF, 32'd1, 32'd2);
    push_request(32'hFFFF_FFFF, 32'd3, 32'd4);
    push_request(32'd86399, 32'd100, 32'd200);
    push_request(32'd86400, 32'd0, 32'hFFFF_FFFF);
    wait_drained();

    // most negative legal offset: local time below zero
    set_offset(-5'sd12);
    push_request(32'd0, 32'd11, 32'd22);
    push_request(32'd43199, 32'd33, 32'd44);
    push_request(32'd43200, 32'h5555_5555, 32'hAAAA_AAAA);
    wait_drained();

    set_offset(5'sd14);
    push_request(32'hFFFF_FFFF, 32'd1000, 32'd2000);
    push_request(32'hFFFF_FF00, 32'd65534, 32'd1);
    wait_drained();

    // offsets beyond the legal range are taken as they are
    set_offset(-5'sd16);
    push_request(32'd100, 32'd7, 32'd8);
    push_request(32'd57700, 32'd9, 32'd10);
    wait_drained();
    set_offset(5'sd15);
    push_request(32'd100, 32'd12, 32'd13);
    push_request(32'd32500, 32'd14, 32'd15);
    wait_drained();

    set_offset(-5'sd12);
    random_phase(PHASE_ITEMS);
    wait_drained();
    set_offset(5'sd14);
    random_phase(PHASE_ITEMS);
    wait_drained();
    set_offset(5'sd0);
    random_phase(PHASE_ITEMS);
    wait_drained();
    set_offset(OFF_W'($urandom_range(0, 31)));
    random_phase(PHASE_ITEMS);
    wait_drained();
    set_offset(5'sd5);
    random_phase(PHASE_ITEMS);
    wait_drained();

    $display("covered %0d requests with %0d minute rolls, %0d results checked",
             requests_sent, rolls_seen, results_seen);
    $display("utc offset written %0d times, ring depth %0d", offsets_set, RING_DEPTH);
    if (fail_count == 0) begin
      $display("rolling_day_reject_window_unit_tb: PASS");
    end else begin
      $display("rolling_day_reject_window_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
